// ===== rtl/lpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg: shared types and constants for the line pixel generator
// Words on both channels, controller commands and status, state encoding.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_RANGE = 64;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 8;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    // One input word: a segment and its color
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t color_red;
        color_t color_green;
        color_t color_blue;
    } lpg_line_t;

    // One result word: a pixel of the segment
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_red;
        color_t pixel_green;
        color_t pixel_blue;
        logic   last_pixel;
    } lpg_pixel_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lpg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_end;
    } lpg_status_t;

    typedef enum logic [1:0] {
        LPG_IDLE,
        LPG_SETUP,
        LPG_RUN
    } lpg_state_t;

    // Saturate a coordinate to the drawable range
    function automatic coord_t clamp_coord(input coord_t v);
        coord_t c;
        c = v;
        if ({1'b0, v} > (COORD_W+1)'(COORD_RANGE - 1))
        begin
            c = COORD_W'(COORD_RANGE - 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/lpg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_ctrl: sequencer for the line pixel generator
// Capture a segment, run a setup state, then step once per pixel.
// ----------------------------------------------------------------------------
module lpg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_cmd_t    cmd,
    output logic                busy
);
    import lpg_pkg::*;

    lpg_state_t state_reg;
    lpg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LPG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            LPG_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = LPG_SETUP;
                end
            end
            LPG_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = LPG_RUN;
            end
            LPG_RUN:
            begin
                cmd.step = 1'b1;
                if (status.at_end)
                begin
                    state_next = LPG_IDLE;
                end
            end
            default:
            begin
                state_next = LPG_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lpg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_datapath: segment registers, minor-axis stepper and output register
// The minor coordinate is kept as quotient and remainder of the exact
// interpolation, corrected by at most one divisor per step.
// ----------------------------------------------------------------------------
module lpg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lpg_pkg::lpg_cmd_t    cmd,
    input  lpg_pkg::lpg_line_t   line,
    output lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_pixel_t  pixel,
    output logic                pixel_valid
);
    import lpg_pkg::*;

    localparam int SUM_W = COORD_W + 2;

    lpg_line_t          line_reg;
    logic               steep_reg;
    coord_t             major_reg;
    coord_t             quot_reg;
    coord_t             rem_reg;
    coord_t             dist_reg;
    coord_t             cnt_reg;
    logic signed [COORD_W:0] delta_reg;
    lpg_pixel_t         pixel_reg;
    logic               valid_reg;

    // setup terms
    coord_t             ax, ay, bx, by;
    coord_t             span_x, span_y;
    logic               steep;
    coord_t             m0, n0, m1, n1;

    // step terms
    logic signed [SUM_W-1:0] rem_sum;
    logic signed [SUM_W-1:0] dist_ext;
    logic               at_end;

    always_comb
    begin
        ax     = line_reg.start_x;
        ay     = line_reg.start_y;
        bx     = line_reg.end_x;
        by     = line_reg.end_y;
        span_x = (ax > bx) ? ax - bx : bx - ax;
        span_y = (ay > by) ? ay - by : by - ay;
        steep  = span_x < span_y;
        m0     = steep ? ay : ax;
        n0     = steep ? ax : ay;
        m1     = steep ? by : bx;
        n1     = steep ? bx : by;
        if (m0 > m1)
        begin
            m0 = m1;
            m1 = steep ? ay : ax;
            n0 = n1;
            n1 = steep ? ax : ay;
        end
    end

    always_comb
    begin
        rem_sum  = $signed({2'b00, rem_reg}) + SUM_W'(delta_reg);
        dist_ext = $signed({2'b00, dist_reg});
        at_end   = cnt_reg == dist_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            line_reg.start_x     <= clamp_coord(line.start_x);
            line_reg.start_y     <= clamp_coord(line.start_y);
            line_reg.end_x       <= clamp_coord(line.end_x);
            line_reg.end_y       <= clamp_coord(line.end_y);
            line_reg.color_red   <= line.color_red;
            line_reg.color_green <= line.color_green;
            line_reg.color_blue  <= line.color_blue;
        end
        if (cmd.setup)
        begin
            steep_reg <= steep;
            major_reg <= m0;
            quot_reg  <= n0;
            rem_reg   <= '0;
            dist_reg  <= m1 - m0;
            cnt_reg   <= '0;
            delta_reg <= $signed({1'b0, n1}) - $signed({1'b0, n0});
        end
        if (cmd.step)
        begin
            pixel_reg.pixel_x     <= steep_reg ? quot_reg : major_reg;
            pixel_reg.pixel_y     <= steep_reg ? major_reg : quot_reg;
            pixel_reg.pixel_red   <= line_reg.color_red;
            pixel_reg.pixel_green <= line_reg.color_green;
            pixel_reg.pixel_blue  <= line_reg.color_blue;
            pixel_reg.last_pixel  <= at_end;
            major_reg <= major_reg + 1'b1;
            cnt_reg   <= cnt_reg + 1'b1;
            if (rem_sum >= dist_ext)
            begin
                rem_reg  <= COORD_W'(rem_sum - dist_ext);
                quot_reg <= quot_reg + 1'b1;
            end
            else if (rem_sum < 0)
            begin
                rem_reg  <= COORD_W'(rem_sum + dist_ext);
                quot_reg <= quot_reg - 1'b1;
            end
            else
            begin
                rem_reg <= COORD_W'(rem_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.step;
        end
    end

    assign status.at_end = at_end;
    assign pixel         = pixel_reg;
    assign pixel_valid   = valid_reg;

endmodule

// ===== rtl/line_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator: rasterize one segment into the pixels it covers
// After start is taken, a setup state precedes the minor-axis stepper,
// which gives one pixel per cycle, d + 1 pixels for a major-axis span d
// (63 at most); the next segment is taken only once the generator is idle.
// Pixel words are strobed for one cycle; the receiver cannot stall.
// Reset clears the sequencer and the strobe; payload registers are not reset.
// ----------------------------------------------------------------------------
module line_pixel_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lpg_pkg::lpg_line_t  line,
    output lpg_pkg::lpg_pixel_t pixel,
    output logic               pixel_valid
);
    import lpg_pkg::*;

    lpg_cmd_t    cmd;
    lpg_status_t status;

    // Sequencer: hold busy from the accept edge until the last step issues
    lpg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: clamp and capture the word, order the endpoints, then
    // advance the major axis by one and the minor remainder by the minor
    // delta each step, folding back by one span when it leaves [0, d).
    lpg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .line        (line),
        .status      (status),
        .pixel       (pixel),
        .pixel_valid (pixel_valid)
    );

    // The last pixel closes the segment: no strobe right after it
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel.last_pixel |=> !pixel_valid)
        else $error("pixel strobe after last pixel");

    // A step never issues while idle
    a_no_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.step)
        else $error("datapath stepped while idle");

    // Every strobe follows a cycle of work
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> $past(busy))
        else $error("pixel strobe without work");

    // An accepted word starts work at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !pixel_valid)
        else $error("accepted word did not start work");

endmodule
